@@ hdl/pbrd_pkg.sv @@
`default_nettype none

package pbrd_pkg;

  // Flag byte that decodes to nothing
  localparam logic [7:0] FLAG_NOP = 8'h80;

  // Configuration register indexes
  localparam logic CFG_WORD_MODE    = 1'b0;
  localparam logic CFG_ROW_CAPACITY = 1'b1;

  localparam logic [13:0] ROW_CAPACITY_RST = 14'd1280;

  // Decoder phase
  typedef enum logic [2:0] {
    PH_FLAG = 3'd0,
    PH_LIT  = 3'd1,
    PH_LIT2 = 3'd2,
    PH_REP0 = 3'd3,
    PH_REP1 = 3'd4
  } phase_t;

  // Per-row decoder state
  typedef struct packed {
    phase_t      phase;
    logic [7:0]  units_left;
    logic [7:0]  held_byte;
    logic [13:0] bytes_written;
    logic        row_stopped;
  } row_state_t;

  // One run of decoded bytes caused by one packed byte
  typedef struct packed {
    logic [8:0] len;   // bytes to emit, 0..256
    logic [7:0] b0;    // byte, or first byte of a word
    logic [7:0] b1;    // second byte of a word
    logic       word;  // alternate b0/b1
  } run_t;

  // Sequencer steps
  typedef enum logic [1:0] {
    STEP_TAKE   = 2'd0,
    STEP_DECODE = 2'd1,
    STEP_EMIT   = 2'd2
  } step_t;

  // Jump conditions
  typedef enum logic [1:0] {
    COND_ALWAYS    = 2'd0,
    COND_IN_BEAT   = 2'd1,
    COND_NO_RUN    = 2'd2,
    COND_LAST_BEAT = 2'd3
  } cond_t;

  // Control word
  typedef struct packed {
    logic  take;     // ready for an input beat
    logic  load;     // commit decoded state and run
    logic  emit;     // present an output beat
    cond_t cond;     // jump condition
    step_t target;   // jump target
    logic  advance;  // step+1 when no jump, else hold
  } ucode_t;

  // Control program
  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t uc;
    unique case (step)
      STEP_TAKE:   uc = '{take: 1'b1, load: 1'b0, emit: 1'b0, cond: COND_IN_BEAT,
                          target: STEP_DECODE, advance: 1'b0};
      STEP_DECODE: uc = '{take: 1'b0, load: 1'b1, emit: 1'b0, cond: COND_NO_RUN,
                          target: STEP_TAKE, advance: 1'b1};
      STEP_EMIT:   uc = '{take: 1'b0, load: 1'b0, emit: 1'b1, cond: COND_LAST_BEAT,
                          target: STEP_TAKE, advance: 1'b0};
      default:     uc = '{take: 1'b0, load: 1'b0, emit: 1'b0, cond: COND_ALWAYS,
                          target: STEP_TAKE, advance: 1'b0};
    endcase
    return uc;
  endfunction

endpackage

`default_nettype wire

@@ hdl/pbrd_step_decode.sv @@
`default_nettype none

module pbrd_step_decode
  import pbrd_pkg::*;
(
  input  row_state_t  state,
  input  logic [7:0]  packed_byte,
  input  logic        row_last,
  input  logic        word_mode,
  input  logic [13:0] row_capacity,
  output row_state_t  state_next,
  output run_t        run
);

  logic [13:0] free_bytes;
  row_state_t  st_a;
  logic        lit_emit;
  logic        rep_req;
  logic [7:0]  rep_b0;
  logic [7:0]  rep_b1;
  logic        rep_word;
  logic [13:0] cap_units;
  logic [7:0]  rep_units;
  logic [8:0]  rep_bytes;
  logic [8:0]  add_bytes;
  logic [7:0]  units_dec;

  // Free room in the row, zero once capacity is reached or lowered below
  assign free_bytes = (state.bytes_written >= row_capacity) ? 14'd0
                                                            : row_capacity - state.bytes_written;
  assign units_dec  = state.units_left - 8'd1;

  // Take one packed byte
  always_comb begin
    st_a     = state;
    lit_emit = 1'b0;
    rep_req  = 1'b0;
    rep_b0   = 8'd0;
    rep_b1   = 8'd0;
    rep_word = 1'b0;
    if (!state.row_stopped) begin
      unique case (state.phase)
        PH_FLAG: begin
          if (free_bytes == 14'd0 || (word_mode && free_bytes == 14'd1)) begin
            st_a.row_stopped = 1'b1;
          end else if (!packed_byte[7]) begin
            st_a.units_left = packed_byte + 8'd1;
            st_a.phase      = PH_LIT;
          end else if (packed_byte != FLAG_NOP) begin
            st_a.units_left = 8'd1 - packed_byte;
            st_a.phase      = PH_REP0;
          end
        end
        PH_LIT, PH_LIT2: begin
          if (free_bytes == 14'd0) begin
            st_a.row_stopped = 1'b1;
          end else begin
            lit_emit = 1'b1;
            if (state.phase == PH_LIT && word_mode) begin
              st_a.phase = PH_LIT2;
            end else begin
              st_a.units_left = units_dec;
              st_a.phase      = (units_dec == 8'd0) ? PH_FLAG : PH_LIT;
            end
          end
        end
        PH_REP0: begin
          if (word_mode) begin
            st_a.held_byte = packed_byte;
            st_a.phase     = PH_REP1;
          end else begin
            rep_req = 1'b1;
            rep_b0  = packed_byte;
          end
        end
        PH_REP1: begin
          rep_req  = 1'b1;
          rep_b0   = state.held_byte;
          rep_b1   = packed_byte;
          rep_word = 1'b1;
        end
        default: st_a.phase = PH_FLAG;
      endcase
    end
    // Row ends while a repeat value is awaited: repeat zeros, or the held byte paired with zero
    if (row_last && !st_a.row_stopped && !rep_req) begin
      if (st_a.phase == PH_REP0) begin
        rep_req  = 1'b1;
        rep_b0   = 8'd0;
        rep_b1   = 8'd0;
        rep_word = word_mode;
      end else if (st_a.phase == PH_REP1) begin
        rep_req  = 1'b1;
        rep_b0   = st_a.held_byte;
        rep_b1   = 8'd0;
        rep_word = 1'b1;
      end
    end
  end

  // Clip a repeat to the free bytes, or to whole free words
  assign cap_units = rep_word ? {1'b0, free_bytes[13:1]} : free_bytes;
  assign rep_units = ({6'd0, st_a.units_left} > cap_units) ? cap_units[7:0] : st_a.units_left;
  assign rep_bytes = rep_word ? {rep_units, 1'b0} : {1'b0, rep_units};
  assign add_bytes = rep_req ? rep_bytes : {8'd0, lit_emit};

  // Commit state and describe the run
  always_comb begin
    state_next               = st_a;
    state_next.bytes_written = state.bytes_written + {5'd0, add_bytes};
    if (rep_req) begin
      state_next.units_left = 8'd0;
      state_next.phase      = PH_FLAG;
    end
    if (row_last) begin
      state_next = '{phase: PH_FLAG, units_left: 8'd0, held_byte: 8'd0,
                     bytes_written: 14'd0, row_stopped: 1'b0};
    end
    run.len  = add_bytes;
    run.b0   = rep_req ? rep_b0 : packed_byte;
    run.b1   = rep_b1;
    run.word = rep_req & rep_word;
  end

endmodule

`default_nettype wire

@@ hdl/packbits_row_decoder_core.sv @@
// Channel   | Dir | tdata (low bit up)                        | tlast
// s_axis    | in  | packed_byte[7:0]                          | row_last
// m_axis    | out | out_bytes[63:0], out_count[67:64], 0 pad  | item_last
// cfg       | in  | cfg_we, cfg_index (0 word_mode, 1 row_capacity), cfg_wdata
//
// A three-step control program (take, decode, emit) runs one packed byte at a time.
// A flag byte passes take and decode; a literal byte or a repeat also passes emit, which sends
// up to BYTES_PER_RESULT bytes per beat, one output beat per cycle while m_axis_tready is high.
// Output stalls hold the emit step and its beat; input is refused until the last beat leaves.
// rst is synchronous: it clears the row state and the step and loads the register defaults.
`default_nettype none

module packbits_row_decoder_core
  import pbrd_pkg::*;
#(
  parameter int BYTES_PER_RESULT = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // packed_byte[7:0]
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,   // out_bytes[63:0], out_count[67:64], zero pad
  output logic             m_axis_tlast,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [13:0] cfg_wdata
);

  localparam logic [3:0] LANES = 4'(BYTES_PER_RESULT);

  logic        word_mode;
  logic [13:0] row_capacity;

  step_t       step;
  step_t       step_next;
  ucode_t      uc;
  logic        cond_true;

  logic [7:0]  in_byte;
  logic        in_last;
  row_state_t  state;
  row_state_t  state_next;
  run_t        run_new;

  logic [8:0]  run_left;
  logic [7:0]  run_b0;
  logic [7:0]  run_b1;
  logic        run_word;
  logic        run_odd;
  logic [3:0]  beat_n;
  logic        last_beat;
  logic [63:0] beat_bytes;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      word_mode    <= 1'b0;
      row_capacity <= ROW_CAPACITY_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_WORD_MODE) begin
        word_mode <= cfg_wdata[0];
      end else begin
        row_capacity <= cfg_wdata;
      end
    end
  end

  // Decode the held byte against the row state
  pbrd_step_decode u_decode (
    .state        (state),
    .packed_byte  (in_byte),
    .row_last     (in_last),
    .word_mode    (word_mode),
    .row_capacity (row_capacity),
    .state_next   (state_next),
    .run          (run_new)
  );

  // Beat size and lane contents
  assign beat_n    = (run_left >= {5'd0, LANES}) ? LANES : run_left[3:0];
  assign last_beat = (run_left <= {5'd0, LANES});

  always_comb begin
    beat_bytes = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < beat_n) begin
        beat_bytes[8*i +: 8] = (run_word && (run_odd ^ 1'(i))) ? run_b1 : run_b0;
      end
    end
  end

  // Sequencer: control word, jump condition, next step
  always_comb begin
    uc = ucode_rom(step);
    case (uc.cond)
      COND_IN_BEAT:   cond_true = s_axis_tvalid;
      COND_NO_RUN:    cond_true = (run_new.len == 9'd0);
      COND_LAST_BEAT: cond_true = m_axis_tready && last_beat;
      default:        cond_true = 1'b1;
    endcase
    if (cond_true) begin
      step_next = uc.target;
    end else if (uc.advance) begin
      step_next = step_t'(step + 2'd1);
    end else begin
      step_next = step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_TAKE;
    end else begin
      step <= step_next;
    end
  end

  // Hold the accepted byte
  always_ff @(posedge clk) begin
    if (uc.take && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  // Row state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{phase: PH_FLAG, units_left: 8'd0, held_byte: 8'd0,
                 bytes_written: 14'd0, row_stopped: 1'b0};
    end else if (uc.load) begin
      state <= state_next;
    end
  end

  // Load the run, then drain it beat by beat
  always_ff @(posedge clk) begin
    if (uc.load) begin
      run_left <= run_new.len;
      run_b0   <= run_new.b0;
      run_b1   <= run_new.b1;
      run_word <= run_new.word;
      run_odd  <= 1'b0;
    end else if (uc.emit && m_axis_tready) begin
      run_left <= run_left - {5'd0, beat_n};
      run_odd  <= run_odd ^ beat_n[0];
    end
  end

  assign s_axis_tready = uc.take;
  assign m_axis_tvalid = uc.emit;
  assign m_axis_tdata  = {4'd0, beat_n, beat_bytes};
  assign m_axis_tlast  = last_beat;

endmodule

`default_nettype wire

@@ test/testbench.sv @@
`default_nettype none

module testbench
  import pbrd_pkg::*;
();

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 8;

  // One output beat: up to eight decoded bytes
  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  count;
    logic        last;
  } out_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;    // packed_byte[7:0]
  logic        s_axis_tlast = 1'b0;  // row_last
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;         // out_bytes[63:0], out_count[67:64], zero pad
  logic        m_axis_tlast;         // item_last
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_WORD_MODE;
  logic [13:0] cfg_wdata = '0;

  packbits_row_decoder_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  // Decoder mirror: configuration and row state
  logic        mode_word = 1'b0;
  logic [13:0] row_cap = ROW_CAPACITY_RST;
  phase_t      row_phase = PH_FLAG;
  logic [7:0]  run_units = '0;
  logic [7:0]  word_hi = '0;
  logic [13:0] row_fill = '0;
  logic        row_full = 1'b0;
  logic [7:0]  decoded[$];

  out_beat_t   beats_due[$];
  out_beat_t   beat_want;
  int          errors = 0;
  int          beats_sent = 0;
  int          cycle_count = 0;
  int          send_idle = 0;
  int          recv_idle = 0;
  int          rx_hold_req = 0;
  int          rx_hold_left = 0;

  always #1 clk = ~clk;

  // Free bytes left in the row; a fill at or above capacity leaves none
  function automatic int unsigned room_left();
    return (row_fill >= row_cap) ? 0 : 32'(row_cap - row_fill);
  endfunction

  function automatic void put_decoded(input logic [7:0] b);
    decoded.push_back(b);
    row_fill = row_fill + 14'd1;
  endfunction

  // Emit a repeat run, cut to the room left (whole words in word mode)
  function automatic void fill_run(input logic [7:0] b0, input logic [7:0] b1,
                                   input logic word);
    int unsigned fr;
    int unsigned cnt;
    fr = room_left();
    cnt = 32'(run_units);
    if (word) begin
      if (cnt > fr / 2) cnt = fr / 2;
      for (int unsigned i = 0; i < cnt; i++) begin
        put_decoded(b0);
        put_decoded(b1);
      end
    end else begin
      if (cnt > fr) cnt = fr;
      for (int unsigned i = 0; i < cnt; i++) put_decoded(b0);
    end
    run_units = '0;
    row_phase = PH_FLAG;
  endfunction

  // Advance the mirror by one packed byte and queue the beats it yields
  function automatic void decode_packed(input logic [7:0] b, input logic last);
    int pos;
    int n;
    logic [63:0] v;
    out_beat_t beat;
    decoded.delete();
    if (!row_full) begin
      case (row_phase)
        PH_FLAG: begin
          if (room_left() < (mode_word ? 2 : 1)) begin
            row_full = 1'b1;
          end else if (b < 8'h80) begin
            run_units = b + 8'd1;
            row_phase = PH_LIT;
          end else if (b != FLAG_NOP) begin
            run_units = 8'(9'd257 - {1'b0, b});
            row_phase = PH_REP0;
          end
        end
        PH_LIT, PH_LIT2: begin
          if (room_left() == 0) begin
            row_full = 1'b1;
          end else begin
            put_decoded(b);
            if (row_phase == PH_LIT && mode_word) begin
              row_phase = PH_LIT2;
            end else begin
              run_units = run_units - 8'd1;
              row_phase = (run_units == 0) ? PH_FLAG : PH_LIT;
            end
          end
        end
        PH_REP0: begin
          if (mode_word) begin
            word_hi = b;
            row_phase = PH_REP1;
          end else begin
            fill_run(b, 8'h00, 1'b0);
          end
        end
        PH_REP1: fill_run(word_hi, b, 1'b1);
        default: row_phase = PH_FLAG;
      endcase
    end
    // End of row: flush a pending repeat with zeros, then clear the row
    if (last) begin
      if (!row_full) begin
        if (row_phase == PH_REP0) fill_run(8'h00, 8'h00, mode_word);
        else if (row_phase == PH_REP1) fill_run(word_hi, 8'h00, 1'b1);
      end
      row_phase = PH_FLAG;
      run_units = '0;
      word_hi = '0;
      row_fill = '0;
      row_full = 1'b0;
    end
    // Pack into beats of up to eight bytes
    pos = 0;
    while (pos < decoded.size()) begin
      n = decoded.size() - pos;
      if (n > 8) n = 8;
      v = '0;
      for (int i = 0; i < n; i++) v |= 64'(decoded[pos + i]) << (8 * i);
      pos += n;
      beat.data = v;
      beat.count = 4'(n);
      beat.last = (pos >= decoded.size());
      beats_due.push_back(beat);
    end
  endfunction

  // Offer one packed byte, with a random gap ahead of it
  task automatic send_packed(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    decode_packed(b, last);
    beats_sent++;
  endtask

  // Stop offering and let every due beat drain out
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (beats_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers while the block is idle
  task automatic configure(input logic wm, input logic [13:0] cap);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= CFG_WORD_MODE;
    cfg_wdata <= {13'd0, wm};
    @(posedge clk);
    cfg_index <= CFG_ROW_CAPACITY;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    mode_word = wm;
    row_cap = cap;
  endtask

  function automatic logic [13:0] pick_capacity();
    case ($urandom_range(3))
      0: return 14'($urandom_range(24));
      1: return 14'($urandom_range(25, 400));
      2: return 14'h3FFF;
      default: return 14'($urandom);
    endcase
  endfunction

  // Build a well-formed row of random runs, sometimes cut short
  task automatic send_row(input int budget);
    logic [7:0] seq[$];
    int n;
    int unit;
    int cut;
    unit = mode_word ? 2 : 1;
    while (seq.size() < budget) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: begin
          n = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(7);
          seq.push_back(8'(n));
          repeat ((n + 1) * unit) seq.push_back(8'($urandom));
        end
        9: seq.push_back(FLAG_NOP);
        default: begin
          n = ($urandom_range(3) == 0) ? $urandom_range(1, 127) : $urandom_range(1, 15);
          seq.push_back(8'(256 - n));
          repeat (unit) seq.push_back(8'($urandom));
        end
      endcase
    end
    cut = seq.size();
    if ($urandom_range(4) == 0) cut = $urandom_range(1, seq.size());
    for (int i = 0; i < cut; i++) send_packed(seq[i], i == cut - 1);
  endtask

  // Random bytes with random row ends, closed by a row end
  task automatic send_noise(input int k);
    repeat (k) send_packed(8'($urandom), $urandom_range(7) == 0);
    send_packed(8'($urandom), 1'b1);
  endtask

  // Literals, no-op flag, longest repeat, repeat of two, cut literal, early end
  task automatic test_byte_runs();
    configure(1'b0, ROW_CAPACITY_RST);
    send_packed(8'h00, 1'b0); send_packed(8'h00, 1'b0);
    send_packed(8'h01, 1'b0); send_packed(8'hFF, 1'b0); send_packed(8'h5A, 1'b0);
    send_packed(FLAG_NOP, 1'b0);
    send_packed(8'h81, 1'b0); send_packed(8'hFF, 1'b0);
    send_packed(8'hFF, 1'b0); send_packed(8'h77, 1'b0);
    send_packed(8'h7F, 1'b0); send_packed(8'h11, 1'b1);
    // Row ends on a repeat flag: zeros are repeated
    send_packed(8'hFE, 1'b1);
  endtask

  // Longest word repeat, and a word repeat whose second byte never comes
  task automatic test_word_runs();
    configure(1'b1, 14'h3FFF);
    send_packed(8'h81, 1'b0); send_packed(8'hAB, 1'b0); send_packed(8'hCD, 1'b0);
    send_packed(8'hFD, 1'b0); send_packed(8'h12, 1'b1);
  endtask

  // Repeat cut to whole words, then the row stops and ignores the rest
  task automatic test_capacity();
    configure(1'b1, 14'd3);
    send_packed(8'hFC, 1'b0); send_packed(8'h01, 1'b0); send_packed(8'h02, 1'b0);
    send_packed(8'h00, 1'b0); send_packed(8'h55, 1'b1);
    configure(1'b0, 14'd0);
    send_packed(8'h00, 1'b1);
  endtask

  // Mode switched inside a word repeat, capacity lowered to the fill
  task automatic test_mid_row_changes();
    configure(1'b1, ROW_CAPACITY_RST);
    send_packed(8'hFF, 1'b0); send_packed(8'h40, 1'b0);
    configure(1'b0, ROW_CAPACITY_RST);
    send_packed(8'h50, 1'b1);
    send_packed(8'h01, 1'b0); send_packed(8'h01, 1'b0);
    configure(1'b0, 14'd1);
    send_packed(8'h02, 1'b1);
  endtask

  // Hold the receiver off while repeats keep arriving
  task automatic test_backpressure();
    configure(1'b0, 14'h3FFF);
    send_idle = 0;
    recv_idle = 0;
    rx_hold_req = 300;
    repeat (6) begin
      send_packed(8'h81, 1'b0);
      send_packed(8'($urandom), 1'b0);
    end
    send_packed(8'h00, 1'b0);
    send_packed(8'($urandom), 1'b1);
    wait_idle();
  endtask

  task automatic test_random(input int sidle, input int ridle, input int count);
    int stop_at;
    send_idle = sidle;
    recv_idle = ridle;
    stop_at = beats_sent + count;
    while (beats_sent < stop_at) begin
      if ($urandom_range(5) == 0) configure(1'($urandom_range(1)), pick_capacity());
      if ($urandom_range(7) == 0) send_noise($urandom_range(1, 8));
      else send_row($urandom_range(3, 24));
    end
    wait_idle();
  endtask

  // Receiver: random stalls, or a long hold-off on request
  always @(posedge clk) begin
    if (rx_hold_req != 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req = 0;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Check each output beat against the oldest due beat
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (beats_due.size() == 0) begin
        $display("%0t: beat with none due, expected nothing, got tdata %h last %b",
                 $time, m_axis_tdata, m_axis_tlast);
        errors++;
      end else begin
        beat_want = beats_due.pop_front();
        if (m_axis_tdata[63:0] !== beat_want.data) begin
          $display("%0t: out_bytes expected %h got %h", $time, beat_want.data,
                   m_axis_tdata[63:0]);
          errors++;
        end
        if (m_axis_tdata[67:64] !== beat_want.count) begin
          $display("%0t: out_count expected %0d got %0d", $time, beat_want.count,
                   m_axis_tdata[67:64]);
          errors++;
        end
        if (m_axis_tlast !== beat_want.last) begin
          $display("%0t: item_last expected %b got %b", $time, beat_want.last,
                   m_axis_tlast);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** packbits_row_decoder_core: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    send_idle = 35;
    recv_idle = 50;
    test_byte_runs();
    test_word_runs();
    test_capacity();
    test_mid_row_changes();
    test_random(35, 50, 120);
    test_random(50, 35, 120);
    test_backpressure();
    test_random(0, 0, 120);
    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("** packbits_row_decoder_core: PASSED **");
    end else begin
      $display("** packbits_row_decoder_core: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
